// ===== rtl/eft_pkg.sv =====
package eft_pkg;

  localparam int unsigned CHANNELS_PER_WORD = 16;
  localparam int unsigned EVENT_QUEUE_DEPTH = 4;

  // scanned bits per word, clipped to the 16-bit word
  localparam int unsigned ScanW = (CHANNELS_PER_WORD < 1)  ? 1 :
                                  (CHANNELS_PER_WORD > 16) ? 16 : CHANNELS_PER_WORD;
  localparam int unsigned LvlW  = 2 * ScanW;
  localparam int unsigned IdxW  = (ScanW > 1) ? $clog2(ScanW) : 1;
  localparam int unsigned ChanW = 5;
  localparam int unsigned TimeW = 64;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;

  localparam int unsigned QDepth = EVENT_QUEUE_DEPTH;
  localparam int unsigned PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  typedef struct packed {
    logic [ScanW-1:0] changed;
    logic [ScanW-1:0] levels;
    logic             hi;
    logic [TimeW-1:0] stamp;
  } eft_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } eft_q_status_t;

endpackage

// ===== rtl/eft_front.sv =====
module eft_front import eft_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic               s_axis_tuser,
  input  eft_q_status_t      q_status_i,
  output logic               push_o,
  output eft_entry_t         entry_o
);

  logic             mode_q, mode_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [TimeW-1:0] time_q, time_d;
  logic             phase_q, phase_d;
  logic             primed_q, primed_d;

  logic             accept;
  logic [ScanW-1:0] word;
  logic [ScanW-1:0] prev;
  logic [ScanW-1:0] changed;
  logic [TimeW-1:0] time_eff;
  logic             phase_eff;
  logic             primed_eff;
  logic             pair_end;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign word          = s_axis_tdata[ScanW-1:0];

  assign time_eff   = s_axis_tuser ? '0 : time_q;
  assign phase_eff  = mode_q && !s_axis_tuser && phase_q;
  assign primed_eff = !s_axis_tuser && primed_q;
  assign pair_end   = !mode_q || phase_eff;

  assign prev    = phase_eff ? lvl_q[LvlW-1:ScanW] : lvl_q[ScanW-1:0];
  assign changed = word ^ prev;

  assign push_o          = accept && primed_eff && (changed != '0);
  assign entry_o.changed = changed;
  assign entry_o.levels  = word;
  assign entry_o.hi      = phase_eff;
  assign entry_o.stamp   = time_eff;

  always_comb begin
    mode_d   = cfg_we_i ? cfg_wdata_i : mode_q;
    lvl_d    = lvl_q;
    time_d   = time_q;
    phase_d  = phase_q;
    primed_d = primed_q;
    if (accept) begin
      if (phase_eff) begin
        lvl_d[LvlW-1:ScanW] = word;
      end else begin
        lvl_d[ScanW-1:0] = word;
      end
      time_d   = pair_end ? time_eff + TimeW'(1) : time_eff;
      phase_d  = mode_q && !phase_eff;
      primed_d = primed_eff || pair_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      lvl_q    <= '0;
      time_q   <= '0;
      phase_q  <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      lvl_q    <= lvl_d;
      time_q   <= time_d;
      phase_q  <= phase_d;
      primed_q <= primed_d;
    end
  end

endmodule

// ===== rtl/eft_fifo.sv =====
module eft_fifo import eft_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  eft_entry_t    entry_i,
  input  logic          pop_i,
  output eft_entry_t    head_o,
  output eft_q_status_t status_o,
  output logic [CntW-1:0] count_o
);

  eft_entry_t      mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    nxt = (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign count_o        = cnt_q;

  always_comb begin
    wr_d  = push_i ? nxt(wr_q) : wr_q;
    rd_d  = pop_i ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/eft_back.sv =====
module eft_back import eft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eft_entry_t          head_i,
  input  eft_q_status_t       q_status_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  eft_entry_t       cur_q, cur_d;
  logic             cur_vld_q, cur_vld_d;
  logic             out_vld_q, out_vld_d;
  logic [ChanW-1:0] out_chan_q, out_chan_d;
  logic             out_rise_q, out_rise_d;
  logic [TimeW-1:0] out_time_q, out_time_d;
  logic             out_last_q, out_last_d;

  logic             out_free;
  logic             emit;
  logic             done;
  logic [IdxW-1:0]  idx;
  logic [ScanW-1:0] rem;
  logic [ChanW:0]   chan_sum;

  // highest set bit first
  always_comb begin
    idx = '0;
    for (int i = 0; i < ScanW; i++) begin
      if (cur_q.changed[i]) begin
        idx = IdxW'(i);
      end
    end
  end

  assign rem      = cur_q.changed & ~(ScanW'(1) << idx);
  assign out_free = !out_vld_q || m_axis_tready;
  assign emit     = cur_vld_q && out_free;
  assign done     = emit && (rem == '0);
  assign pop_o    = !q_status_i.empty && (!cur_vld_q || done);
  assign chan_sum = (ChanW + 1)'(idx) + (cur_q.hi ? (ChanW + 1)'(ScanW) : '0);

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    if (pop_o) begin
      cur_d     = head_i;
      cur_vld_d = 1'b1;
    end else if (done) begin
      cur_vld_d = 1'b0;
    end else if (emit) begin
      cur_d.changed = rem;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_chan_d = out_chan_q;
    out_rise_d = out_rise_q;
    out_time_d = out_time_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_chan_d = chan_sum[ChanW-1:0];
      out_rise_d = cur_q.levels[idx];
      out_time_d = cur_q.stamp;
      out_last_d = (rem == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_chan_q <= out_chan_d;
    out_rise_q <= out_rise_d;
    out_time_q <= out_time_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_time_q, out_rise_q, out_chan_q};

endmodule

// ===== rtl/multichannel_edge_timestamper_unit.sv =====
// channel   dir  payload
// s_axis    in   tdata[15:0] sample_word, tuser restart
// m_axis    out  tdata[4:0] channel_number, [5] rising, [69:6] edge_time; tlast last_event
// cfg       in   cfg_we_i / cfg_wdata_i: channel_mode
//
// One input word per cycle while the event queue has room; a word with no change
// or a reference word produces nothing.
// Events leave the scanner one per cycle while the output register is free, one event per changed channel of a word.
// Reset clears levels, time, phase and the queue; no clearing pass.
// Input stalls only when the event queue is full; the output register decouples m_axis.
module multichannel_edge_timestamper_unit import eft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] sample_word
  input  logic                s_axis_tuser,   // [0] restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [4:0] channel_number, [5] rising,
                                              // [69:6] edge_time, [71:70] zero
  output logic                m_axis_tlast
);

  logic            push;
  logic            pop;
  eft_entry_t      entry;
  eft_entry_t      head;
  eft_q_status_t   q_status;
  logic [CntW-1:0] q_count;

  eft_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (entry)
  );

  eft_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status),
    .count_o  (q_count)
  );

  eft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QDepth)) else $error("queue count out of range");
`endif

endmodule
